### rtl/core/ctd_pkg.sv
package ctd_pkg;

	// pad count and derived address width
	localparam int PADS = 12;
	localparam int PAD_AW = (PADS > 1) ? $clog2(PADS) : 1;
	localparam logic [4:0] PAD_LIMIT = 5'(PADS);

	// stream widths
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 64;

	// configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// register indexes
	localparam logic [2:0] REG_TOUCH_THR   = 3'd0;
	localparam logic [2:0] REG_RELEASE_THR = 3'd1;
	localparam logic [2:0] REG_ARM_THR     = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE    = 3'd3;
	localparam logic [2:0] REG_MAX_HOLD    = 3'd4;
	localparam logic [2:0] REG_ARM_LIMIT   = 3'd5;
	localparam logic [2:0] REG_SEED        = 3'd6;

	// register reset values
	localparam logic [9:0]  RST_TOUCH_THR   = 10'd5;
	localparam logic [9:0]  RST_RELEASE_THR = 10'd3;
	localparam logic [9:0]  RST_ARM_THR     = 10'd3;
	localparam logic [7:0]  RST_DEBOUNCE    = 8'd2;
	localparam logic [15:0] RST_MAX_HOLD    = 16'd3000;
	localparam logic [15:0] RST_ARM_LIMIT   = 16'd100;
	localparam logic [7:0]  RST_SEED        = 8'd25;

	// tracking shifts
	localparam logic [3:0] TRACK_FAST = 4'd6;
	localparam logic [3:0] TRACK_SLOW = 4'd11;

	typedef struct packed {
		logic [9:0]  touch_threshold;
		logic [9:0]  release_threshold;
		logic [9:0]  arm_threshold;
		logic [7:0]  debounce_count;
		logic [15:0] max_hold_ms;
		logic [15:0] arm_hold_limit;
		logic [7:0]  seed_samples;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  pad;
		logic [9:0]  sample;
		logic        read_failed;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [3:0]         pad_out;
		logic               skipped;
		logic               touched;
		logic               pressed;
		logic               released;
		logic               force_released;
		logic signed [10:0] delta;
		logic [9:0]         baseline;
		logic [31:0]        press_count;
	} res_t;

	// per-pad state kept across reset commands
	typedef struct packed {
		logic [11:0] baseline_q2;
		logic [31:0] presses;
	} ent_a_t;

	// per-pad state cleared by a reset command
	typedef struct packed {
		logic [11:0] settled_q2;
		logic        seeded;
		logic [7:0]  seed_count;
		logic        held;
		logic [7:0]  touch_run;
		logic [7:0]  release_run;
		logic [15:0] armed_polls;
		logic [31:0] hold_start_ms;
	} ent_b_t;

	// one tracking step of b toward t, minimum step of one
	function automatic logic [11:0] track_q2(input logic [11:0] b, input logic [11:0] t,
		input logic [3:0] sh);
		logic [12:0] diff;
		logic [12:0] rnd;
		logic [12:0] st;
		logic [11:0] res;
		diff = 13'd0;
		rnd = (13'd1 << sh) - 13'd1;
		st = 13'd0;
		res = b;
		if (t > b) begin
			diff = {1'b0, t} - {1'b0, b};
			st = diff >> sh;
			if (st == 13'd0) st = 13'd1;
			res = 12'({1'b0, b} + st);
		end else if (t < b) begin
			diff = {1'b0, b} - {1'b0, t};
			st = (diff + rnd) >> sh;
			if (st == 13'd0) st = 13'd1;
			res = 12'({1'b0, b} - st);
		end
		return res;
	endfunction

endpackage

### rtl/core/ctd_cfg_regs.sv
module ctd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ctd_pkg::APB_AW-1:0]  paddr,
	input  logic [ctd_pkg::APB_DW-1:0]  pwdata,
	output logic [ctd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output ctd_pkg::cfg_t               cfg
);
	import ctd_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.touch_threshold   <= RST_TOUCH_THR;
			cfg_q.release_threshold <= RST_RELEASE_THR;
			cfg_q.arm_threshold     <= RST_ARM_THR;
			cfg_q.debounce_count    <= RST_DEBOUNCE;
			cfg_q.max_hold_ms       <= RST_MAX_HOLD;
			cfg_q.arm_hold_limit    <= RST_ARM_LIMIT;
			cfg_q.seed_samples      <= RST_SEED;
		end else if (wr) begin
			unique case (idx)
				REG_TOUCH_THR:   cfg_q.touch_threshold   <= pwdata[9:0];
				REG_RELEASE_THR: cfg_q.release_threshold <= pwdata[9:0];
				REG_ARM_THR:     cfg_q.arm_threshold     <= pwdata[9:0];
				REG_DEBOUNCE:    cfg_q.debounce_count    <= pwdata[7:0];
				REG_MAX_HOLD:    cfg_q.max_hold_ms       <= pwdata[15:0];
				REG_ARM_LIMIT:   cfg_q.arm_hold_limit    <= pwdata[15:0];
				REG_SEED:        cfg_q.seed_samples      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TOUCH_THR:   prdata = APB_DW'(cfg_q.touch_threshold);
			REG_RELEASE_THR: prdata = APB_DW'(cfg_q.release_threshold);
			REG_ARM_THR:     prdata = APB_DW'(cfg_q.arm_threshold);
			REG_DEBOUNCE:    prdata = APB_DW'(cfg_q.debounce_count);
			REG_MAX_HOLD:    prdata = APB_DW'(cfg_q.max_hold_ms);
			REG_ARM_LIMIT:   prdata = APB_DW'(cfg_q.arm_hold_limit);
			REG_SEED:        prdata = APB_DW'(cfg_q.seed_samples);
			default:         prdata = '0;
		endcase
	end

endmodule

### rtl/core/ctd_state_ram.sv
module ctd_state_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [ctd_pkg::PAD_AW-1:0]  rd_addr,
	output ctd_pkg::ent_a_t             rd_a,
	output ctd_pkg::ent_b_t             rd_b,
	input  logic                        wr_en,
	input  logic [ctd_pkg::PAD_AW-1:0]  wr_addr,
	input  ctd_pkg::ent_a_t             wr_a,
	input  ctd_pkg::ent_b_t             wr_b,
	input  logic                        clr_b
);
	import ctd_pkg::*;

	ent_a_t     mem_a [PADS];
	ent_b_t     mem_b [PADS];
	logic [PADS-1:0] va_q;
	logic [PADS-1:0] vb_q;
	ent_a_t     rd_a_q;
	ent_b_t     rd_b_q;
	logic       ok_a_q;
	logic       ok_b_q;
	logic       fwd;

	assign fwd = wr_en && (wr_addr == rd_addr);

	// memory write and registered read with forwarding of a same-cycle write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_a;
			mem_b[wr_addr] <= wr_b;
		end
		if (rd_en) begin
			rd_a_q <= fwd ? wr_a : mem_a[rd_addr];
			rd_b_q <= fwd ? wr_b : mem_b[rd_addr];
		end
	end

	// valid bits: unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q   <= '0;
			vb_q   <= '0;
			ok_a_q <= 1'b0;
			ok_b_q <= 1'b0;
		end else begin
			if (clr_b) begin
				vb_q <= '0;
			end
			if (wr_en) begin
				va_q[wr_addr] <= 1'b1;
				vb_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ok_a_q <= fwd || va_q[rd_addr];
				ok_b_q <= !clr_b && (fwd || vb_q[rd_addr]);
			end
		end
	end

	assign rd_a = ok_a_q ? rd_a_q : '0;
	assign rd_b = ok_b_q ? rd_b_q : '0;

endmodule

### rtl/core/ctd_pad_logic.sv
module ctd_pad_logic (
	input  ctd_pkg::cfg_t   cfg,
	input  ctd_pkg::req_t   req,
	input  ctd_pkg::ent_a_t st_a,
	input  ctd_pkg::ent_b_t st_b,
	output ctd_pkg::ent_a_t nxt_a,
	output ctd_pkg::ent_b_t nxt_b,
	output logic            wr,
	output logic            clr_all,
	output ctd_pkg::res_t   res
);
	import ctd_pkg::*;

	logic [7:0]         dbc_eff;
	logic [7:0]         seed_eff;
	logic signed [10:0] delta;
	logic [10:0]        mag_w;
	logic [9:0]         mag;
	logic [11:0]        tgt;
	logic [7:0]         sc_inc;
	logic [7:0]         tr_inc;
	logic [7:0]         rr_inc;
	logic [15:0]        ap_inc;
	logic [11:0]        trk_fast;
	logic [11:0]        trk_slow;
	logic [31:0]        held_ms;
	logic               in_range;

	// shared arithmetic of the step
	always_comb begin
		dbc_eff  = (cfg.debounce_count == 8'd0) ? 8'd1 : cfg.debounce_count;
		seed_eff = (cfg.seed_samples == 8'd0) ? 8'd1 : cfg.seed_samples;
		delta    = $signed({1'b0, st_a.baseline_q2[11:2]}) - $signed({1'b0, req.sample});
		mag_w    = delta[10] ? 11'(-delta) : 11'(delta);
		mag      = mag_w[9:0];
		tgt      = {req.sample, 2'b00};
		sc_inc   = (st_b.seed_count == 8'hFF) ? st_b.seed_count : st_b.seed_count + 8'd1;
		tr_inc   = (st_b.touch_run == 8'hFF) ? st_b.touch_run : st_b.touch_run + 8'd1;
		rr_inc   = (st_b.release_run == 8'hFF) ? st_b.release_run : st_b.release_run + 8'd1;
		ap_inc   = (st_b.armed_polls == 16'hFFFF) ? st_b.armed_polls
			: st_b.armed_polls + 16'd1;
		trk_fast = track_q2(st_a.baseline_q2, tgt, TRACK_FAST);
		trk_slow = track_q2(st_a.baseline_q2, tgt, TRACK_SLOW);
		held_ms  = req.now_ms - st_b.hold_start_ms;
		in_range = ({1'b0, req.pad} < PAD_LIMIT);
	end

	// per-pad update and result
	always_comb begin
		nxt_a   = st_a;
		nxt_b   = st_b;
		wr      = 1'b0;
		clr_all = 1'b0;
		res     = '0;
		res.pad_out = req.pad;
		if (req.kind) begin
			// reset command clears all pads' debounce, hold and seed state; baselines and press counts stay
			clr_all     = 1'b1;
			res.pad_out = 4'd0;
			res.skipped = 1'b1;
		end else if (!in_range) begin
			res.skipped = 1'b1;
		end else if (req.read_failed) begin
			res.skipped     = 1'b1;
			res.touched     = st_b.held;
			res.baseline    = st_a.baseline_q2[11:2];
			res.press_count = st_a.presses;
		end else if (!st_b.seeded) begin
			// seeding
			wr                = 1'b1;
			nxt_a.baseline_q2 = tgt;
			nxt_b.settled_q2  = tgt;
			nxt_b.seed_count  = sc_inc;
			nxt_b.seeded      = (sc_inc >= seed_eff);
			res.skipped       = 1'b1;
			res.touched       = st_b.held;
			res.baseline      = req.sample;
			res.press_count   = st_a.presses;
		end else begin
			wr = 1'b1;
			if (!st_b.held) begin
				// baseline tracking and arming
				if (mag < cfg.arm_threshold) begin
					nxt_a.baseline_q2 = trk_fast;
					nxt_b.settled_q2  = trk_fast;
					nxt_b.armed_polls = 16'd0;
				end else begin
					nxt_b.armed_polls = ap_inc;
					if (ap_inc > cfg.arm_hold_limit) begin
						nxt_a.baseline_q2 = trk_slow;
					end
				end
				// touch debounce
				if (mag > cfg.touch_threshold) begin
					nxt_b.touch_run = tr_inc;
					if (tr_inc >= dbc_eff) begin
						nxt_b.held          = 1'b1;
						nxt_b.touch_run     = 8'd0;
						nxt_b.release_run   = 8'd0;
						nxt_a.presses       = st_a.presses + 32'd1;
						nxt_b.hold_start_ms = req.now_ms;
						nxt_a.baseline_q2   = nxt_b.settled_q2;
						res.pressed         = 1'b1;
					end
				end else begin
					nxt_b.touch_run = 8'd0;
				end
			end else begin
				// release debounce
				if (mag < cfg.release_threshold) begin
					nxt_b.release_run = rr_inc;
					if (rr_inc >= dbc_eff) begin
						nxt_b.held          = 1'b0;
						nxt_b.release_run   = 8'd0;
						nxt_b.hold_start_ms = 32'd0;
						nxt_b.armed_polls   = 16'd0;
						res.released        = 1'b1;
					end
				end else begin
					nxt_b.release_run = 8'd0;
				end
				// hold timeout
				if (nxt_b.held && (held_ms > {16'd0, cfg.max_hold_ms})) begin
					nxt_b.held          = 1'b0;
					nxt_b.release_run   = 8'd0;
					nxt_b.hold_start_ms = 32'd0;
					nxt_b.armed_polls   = 16'd0;
					nxt_a.baseline_q2   = tgt;
					nxt_b.settled_q2    = tgt;
					res.force_released  = 1'b1;
				end
			end
			res.touched     = nxt_b.held;
			res.delta       = delta;
			res.baseline    = nxt_a.baseline_q2[11:2];
			res.press_count = nxt_a.presses;
		end
	end

endmodule

### rtl/core/capacitive_touch_detector.sv
// channel   dir  handshake                 contents
// s_axis    in   s_axis_tvalid/tready      one pad sample or a reset-all command
// m_axis    out  m_axis_tvalid/tready      one result per request
// apb       in   psel/penable/pready       seven configuration registers
//
// one request per cycle sustained while m_axis_tready is high; stage one registers the
// request and reads the pad state memory, stage two updates it, writes it back and
// registers the result; a same-pad write is forwarded into the next read
// a result waiting on m_axis_tready holds stage two, and s_axis_tready drops while it is full
// reset clears the memory valid bits so all pad state reads as zero
module capacitive_touch_detector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// pad[3:0], sample[13:4], read_failed[14], now_ms[46:15], zero[47]
	input  logic [ctd_pkg::S_DATA_W-1:0] s_axis_tdata,
	// kind[0]
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// pad_out[3:0], skipped[4], touched[5], pressed[6], released[7],
	// force_released[8], delta[19:9], baseline[29:20], press_count[61:30], zero[63:62]
	output logic [ctd_pkg::M_DATA_W-1:0] m_axis_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ctd_pkg::APB_AW-1:0]  paddr,
	input  logic [ctd_pkg::APB_DW-1:0]  pwdata,
	output logic [ctd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import ctd_pkg::*;

	cfg_t   cfg;
	req_t   req_in;
	req_t   req_s1;
	logic   vld_s1;
	res_t   res_q;
	logic   out_vld_q;
	logic   adv;
	logic   acc;
	logic   rd_en;
	ent_a_t rd_a;
	ent_b_t rd_b;
	ent_a_t nxt_a;
	ent_b_t nxt_b;
	logic   upd_wr;
	logic   upd_clr;
	res_t   upd_res;
	logic   wr_en;
	logic   clr_b;

	// unpack the request
	always_comb begin
		req_in.kind        = s_axis_tuser;
		req_in.pad         = s_axis_tdata[3:0];
		req_in.sample      = s_axis_tdata[13:4];
		req_in.read_failed = s_axis_tdata[14];
		req_in.now_ms      = s_axis_tdata[46:15];
	end

	// handshake
	assign adv = vld_s1 && (!out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign rd_en = acc && !req_in.kind && ({1'b0, req_in.pad} < PAD_LIMIT);
	assign wr_en = adv && upd_wr;
	assign clr_b = adv && upd_clr;

	ctd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ctd_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (req_in.pad[PAD_AW-1:0]),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.wr_en   (wr_en),
		.wr_addr (req_s1.pad[PAD_AW-1:0]),
		.wr_a    (nxt_a),
		.wr_b    (nxt_b),
		.clr_b   (clr_b)
	);

	ctd_pad_logic u_logic (
		.cfg     (cfg),
		.req     (req_s1),
		.st_a    (rd_a),
		.st_b    (rd_b),
		.nxt_a   (nxt_a),
		.nxt_b   (nxt_b),
		.wr      (upd_wr),
		.clr_all (upd_clr),
		.res     (upd_res)
	);

	// stage one request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1 <= req_in;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= upd_res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {2'b00, res_q.press_count, res_q.baseline, res_q.delta,
		res_q.force_released, res_q.released, res_q.pressed, res_q.touched,
		res_q.skipped, res_q.pad_out};

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, req_s1.pad} < PAD_LIMIT))
		else $error("state write to a pad out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !clr_b)
		else $error("state write and reset-all in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(adv))
		else $error("result shown without a stage advance");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.skipped |->
		!res_q.pressed && !res_q.released && !res_q.force_released)
		else $error("skipped result carries an event");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(res_q.pressed && (res_q.released || res_q.force_released)))
		else $error("press and release on one step");

endmodule
